[design/fir_pkg.sv]
package fir_pkg;

    localparam int TAPS_DEF         = 20;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_W           = 16;
    localparam int COEF_FRAC        = 15;
    localparam int ROM_LEN          = 20;
    localparam int ROM_AW           = 5;

    // Symmetric Q1.15 coefficient set, round(c * 32768).
    localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_LEN] = '{
        -16'sd152,  16'sd287,   16'sd190,   -16'sd950,  16'sd311,
        16'sd1566,  -16'sd985,  -16'sd3302, 16'sd4007,  16'sd15405,
        16'sd15405, 16'sd4007,  -16'sd3302, -16'sd985,  16'sd1566,
        16'sd311,   -16'sd950,  16'sd190,   16'sd287,   -16'sd152
    };

    typedef struct packed {
        logic valid;
        logic first;
    } t_mac_ctl;

    typedef struct packed {
        logic rotate;
        logic load;
    } t_dly_ctl;

    // Taps past the end of the table weigh zero.
    function automatic logic signed [COEF_W-1:0] coef_at(input int k);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (k >= 0 && k < ROM_LEN) begin
            c = COEF_ROM[k[ROM_AW-1:0]];
        end
        return c;
    endfunction

endpackage

[design/fir_if.sv]
interface fir_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           sample_last;

    modport source (output valid, output sample, output sample_last, input ready);
    modport sink   (input valid, input sample, input sample_last, output ready);
endinterface

interface fir_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_sample;
    logic                           out_last;

    modport source (output valid, output out_sample, output out_last, input ready);
    modport sink   (input valid, input out_sample, input out_last, output ready);
endinterface

[design/fir_delay.sv]
module fir_delay
    import fir_pkg::*;
#(
    parameter int TAPS         = TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dly_ctl                       i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_head
);

    localparam int DLY_N = TAPS - 1;

    logic signed [SAMPLE_WIDTH-1:0] r_dly [DLY_N];

    // The line rotates so that each stored sample passes the head in turn.
    // On the final tap the oldest sample sits at the head and is replaced by
    // the new one, which leaves the line shifted by one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLY_N; i++) begin
                r_dly[i] <= '0;
            end
        end else if (i_ctl.load) begin
            r_dly[0] <= i_x;
        end else if (i_ctl.rotate) begin
            for (int i = 0; i < DLY_N - 1; i++) begin
                r_dly[i] <= r_dly[i+1];
            end
            r_dly[DLY_N-1] <= r_dly[0];
        end
    end

    assign o_head = r_dly[0];

endmodule

[design/fir_mac.sv]
module fir_mac
    import fir_pkg::*;
#(
    parameter int TAPS         = TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_mac_ctl                       i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_a,
    input  logic signed [COEF_W-1:0]       i_b,
    output logic signed [SAMPLE_WIDTH-1:0] o_result
);

    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
    localparam int SUM_W  = ACC_W - COEF_FRAC;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF_LSB =
        {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_p_ctl;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [SUM_W-1:0]  w_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else begin
            r_p_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= i_a * i_b;
        end
    end

    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (r_p_ctl.valid) begin
            r_acc <= r_p_ctl.first ? w_prod_ext : r_acc + w_prod_ext;
        end
    end

    // Round half up, then an arithmetic shift gives floor of the biased sum.
    assign w_rnd   = r_acc + HALF_LSB;
    assign w_shift = w_rnd[ACC_W-1:COEF_FRAC];

    always_comb begin
        if (w_shift > SAT_MAX) begin
            o_result = SAT_MAX[SAMPLE_WIDTH-1:0];
        end else if (w_shift < SAT_MIN) begin
            o_result = SAT_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            o_result = w_shift[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

[design/fir_filter_20_tap.sv]
// Each request runs through S_MAC over every tap, then S_DRAIN and S_ROUND,
// before its result enters the output register. A last sample yields TAPS
// outputs from the single shared multiplier before a new request is taken.
// The output register lets a new request in while a result waits.
// Synchronous active-low reset clears the delay line and all control state.
module fir_filter_20_tap
    import fir_pkg::*;
#(
    parameter int TAPS         = TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fir_in_if.sink    i_in,
    fir_out_if.source o_out
);

    localparam int KW = $clog2(TAPS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_ROUND = 4'b1000
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [KW-1:0]                  r_k;
    logic [KW-1:0]                  r_tail;
    logic                           r_flush;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                           r_out_last;

    t_mac_ctl                       w_mac_ctl;
    t_dly_ctl                       w_dly_ctl;
    logic signed [SAMPLE_WIDTH-1:0] w_head;
    logic signed [SAMPLE_WIDTH-1:0] w_operand;
    logic signed [COEF_W-1:0]       w_coef;
    logic signed [SAMPLE_WIDTH-1:0] w_result;
    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_load_out;
    logic                           w_k_last;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_load_out = (r_state == S_ROUND) && w_out_free;
    assign w_k_last   = (r_k == KW'(TAPS - 1));

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (w_k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (w_out_free) begin
                    n_state = (r_tail != '0) ? S_MAC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_tail  <= '0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_tail  <= i_in.sample_last ? KW'(TAPS - 1) : '0;
                r_flush <= i_in.sample_last;
            end else if (w_load_out) begin
                if (r_tail != '0) begin
                    r_tail <= r_tail - 1'b1;
                end else begin
                    r_flush <= 1'b0;
                end
            end
            if (r_state == S_MAC) begin
                r_k <= w_k_last ? '0 : r_k + 1'b1;
            end
        end
    end

    // Tail outputs run with zero shifted in.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_in.sample;
        end else if (w_load_out) begin
            r_x <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_sample <= w_result;
            r_out_last   <= r_flush && (r_tail == '0);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_sample = r_out_sample;
    assign o_out.out_last   = r_out_last;

    assign w_coef    = coef_at(int'(r_k));
    assign w_operand = (r_k == '0) ? r_x : w_head;

    assign w_mac_ctl.valid = (r_state == S_MAC);
    assign w_mac_ctl.first = (r_k == '0);

    assign w_dly_ctl.rotate = (r_state == S_MAC) && (r_k != '0) && !w_k_last;
    assign w_dly_ctl.load   = (r_state == S_MAC) && w_k_last;

    fir_delay #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_delay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dly_ctl),
        .i_x     (r_x),
        .o_head  (w_head)
    );

    fir_mac #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_a      (w_operand),
        .i_b      (w_coef),
        .o_result (w_result)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import fir_pkg::*;

    localparam int FIR_TAPS    = TAPS_DEF;
    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 100;

    localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

    // Q1.15 weights of the filter, mirrored about the center.
    localparam int FIR_WEIGHTS [20] = '{
        -152, 287, 190, -950, 311, 1566, -985, -3302, 4007, 15405,
        15405, 4007, -3302, -985, 1566, 311, -950, 190, 287, -152
    };

    typedef struct packed {
        logic signed [SW-1:0] smp;
        logic                 last;
    } t_filtered;

    logic i_clk;
    logic i_rst_n;

    fir_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
    fir_out_if #(.SAMPLE_WIDTH(SW)) out_if ();

    fir_filter_20_tap #(
        .TAPS        (FIR_TAPS),
        .SAMPLE_WIDTH(SW)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    logic signed [SW-1:0] sample_history [FIR_TAPS-1];
    t_filtered            pending_outputs [$];
    t_filtered            oldest_output;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;
    int samples_sent   = 0;
    int blocks_flushed = 0;
    int outputs_seen   = 0;
    int cycle_count    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One output of the convolution for new sample x, then x enters the history.
    function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] x);
        longint acc;
        longint rounded;
        acc = longint'(FIR_WEIGHTS[0]) * longint'(x);
        for (int k = 1; k < FIR_TAPS; k++) begin
            if (k < 20) begin
                acc += longint'(FIR_WEIGHTS[k]) * longint'(sample_history[k-1]);
            end
        end
        // Round half up, then floor by the arithmetic shift.
        rounded = (acc + (longint'(1) << 14)) >>> 15;
        if (rounded > longint'(SMP_MAX)) begin
            rounded = longint'(SMP_MAX);
        end
        if (rounded < longint'(SMP_MIN)) begin
            rounded = longint'(SMP_MIN);
        end
        for (int k = FIR_TAPS - 2; k > 0; k--) begin
            sample_history[k] = sample_history[k-1];
        end
        sample_history[0] = x;
        return rounded[SW-1:0];
    endfunction

    task automatic push_filter_outputs(input logic signed [SW-1:0] x, input logic last);
        t_filtered res;
        res.smp  = filter_sample(x);
        res.last = 1'b0;
        pending_outputs.push_back(res);
        if (last) begin
            // The flush runs zeros through the whole history.
            for (int t = 0; t < FIR_TAPS - 1; t++) begin
                res.smp  = filter_sample('0);
                res.last = (t == FIR_TAPS - 2);
                pending_outputs.push_back(res);
            end
            for (int k = 0; k < FIR_TAPS - 1; k++) begin
                sample_history[k] = '0;
            end
            blocks_flushed++;
        end
    endtask

    task automatic send_sample(input logic signed [SW-1:0] x, input logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid       <= 1'b0;
            in_if.sample      <= SW'($urandom());
            in_if.sample_last <= 1'($urandom_range(1));
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.sample      <= x;
        in_if.sample_last <= last;
        do @(posedge i_clk); while (!in_if.ready);
        push_filter_outputs(x, last);
        samples_sent++;
    endtask

    // Hold off new requests until every predicted output has been checked.
    task automatic wait_all_outputs();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_outputs.size() != 0);
    endtask

    task automatic test_impulse_response();
        send_sample(SMP_MAX, 1'b1);
        send_sample(SMP_MIN, 1'b1);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b1);
    endtask

    // Four equal full-scale samples line up with the four largest weights
    // during the flush, which drives the sum past both limits.
    task automatic test_saturation();
        for (int i = 0; i < 4; i++) begin
            send_sample(SMP_MAX, i == 3);
        end
        for (int i = 0; i < 4; i++) begin
            send_sample(SMP_MIN, i == 3);
        end
    endtask

    task automatic test_bit_patterns();
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shAAAA, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b1);
        wait_all_outputs();
    endtask

    task automatic test_random_blocks(input int n_items, input int idle_pct,
                                      input int stall_pct);
        int                   sent;
        int                   blk_len;
        logic signed [SW-1:0] x;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_items) begin
            if ($urandom_range(9) < 3) begin
                blk_len = $urandom_range(1, 3);
            end else begin
                blk_len = $urandom_range(4, 40);
            end
            for (int i = 0; i < blk_len && sent < n_items; i++) begin
                case ($urandom_range(9))
                    0: x = SMP_MAX;
                    1: x = SMP_MIN;
                    2: x = SW'(int'($urandom_range(7)) - 4);
                    default: x = SW'($urandom());
                endcase
                send_sample(x, (i == blk_len - 1) || (sent == n_items - 1));
                sent++;
                // Now and then the sender stops mid-block until the block is idle.
                if ($urandom_range(59) == 0) begin
                    wait_all_outputs();
                end
            end
        end
        wait_all_outputs();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            outputs_seen++;
            if (pending_outputs.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected output: expected none, got out_sample %0d out_last %0b",
                             $time, out_if.out_sample, out_if.out_last);
                end
            end else begin
                oldest_output = pending_outputs.pop_front();
                if (out_if.out_sample !== oldest_output.smp) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: out_sample mismatch: expected %0d, got %0d",
                                 $time, oldest_output.smp, out_if.out_sample);
                    end
                end
                if (out_if.out_last !== oldest_output.last) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: out_last mismatch: expected %0b, got %0b",
                                 $time, oldest_output.last, out_if.out_last);
                    end
                end
            end
        end
        out_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d outputs outstanding", $time, pending_outputs.size());
            $display("** fir_filter_20_tap: FAILED **");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < FIR_TAPS - 1; k++) begin
            sample_history[k] = '0;
        end
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.sample      <= '0;
        in_if.sample_last <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_impulse_response();
        test_saturation();
        test_bit_patterns();
        test_random_blocks(80, 0, 0);
        test_random_blocks(80, 51, 0);
        test_random_blocks(80, 0, 51);
        test_random_blocks(80, 22, 22);

        // Watch for stray outputs once everything predicted has arrived.
        recv_stall_pct = 0;
        repeat (2 * (FIR_TAPS + 3)) @(posedge i_clk);

        $display("Sent %0d samples in %0d flushed blocks and checked %0d outputs,",
                 samples_sent, blocks_flushed, outputs_seen);
        $display("covering full-scale, saturating and random data under four pacing mixes.");
        if (err_count == 0) begin
            $display("** fir_filter_20_tap: PASSED **");
        end else begin
            $display("** fir_filter_20_tap: FAILED **");
        end
        $finish;
    end

endmodule
